// ----- hdl/sr2s_pkg.sv -----
// Shared types, constants and lookup functions for the radix-to-symbols converter.
package sr2s_pkg;

  // Character codes used by the alphabet check and the output stream
  localparam logic [7:0] SYM_SPACE = 8'h20;
  localparam logic [7:0] SYM_TILDE = 8'h7E;
  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;

  // Largest supported alphabet
  localparam logic [4:0] MAX_RADIX = 5'd16;

  // Register indexes, taken from paddr[4:3]
  localparam logic [1:0] REG_BASE_LENGTH  = 2'd0;
  localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_RECIP,
    ST_MUL_BACK,
    ST_FIX,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // Symbol for a digit value out of the two alphabet words
  function automatic logic [7:0] symbol_at(input logic [63:0] lo, input logic [63:0] hi,
                                           input logic [3:0] v);
    logic [63:0] word;
    word = v[3] ? hi : lo;
    return word[{v[2:0], 3'b000} +: 8];
  endfunction

  // floor(2^32 / radix); the quotient estimate from it is low by at most one
  function automatic logic [31:0] recip_of(input logic [4:0] radix);
    logic [31:0] r;
    case (radix)
      5'd2:    r = 32'h8000_0000;
      5'd3:    r = 32'h5555_5555;
      5'd4:    r = 32'h4000_0000;
      5'd5:    r = 32'h3333_3333;
      5'd6:    r = 32'h2AAA_AAAA;
      5'd7:    r = 32'h2492_4924;
      5'd8:    r = 32'h2000_0000;
      5'd9:    r = 32'h1C71_C71C;
      5'd10:   r = 32'h1999_9999;
      5'd11:   r = 32'h1745_D174;
      5'd12:   r = 32'h1555_5555;
      5'd13:   r = 32'h13B1_3B13;
      5'd14:   r = 32'h1249_2492;
      5'd15:   r = 32'h1111_1111;
      5'd16:   r = 32'h1000_0000;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/signed_radix_to_symbols_unit.sv -----
// Top level: signed integer to text in a configured radix, one symbol word per strobe.
//
// Configure through the APB port first: base_length at 0x00, digit_symbols_low at
// 0x08 and digit_symbols_high at 0x10 (64-bit data; pready is tied high).
// Pulse start with number while busy is low; the number is taken at that edge.
// With a bad alphabet the number is taken and dropped: no words come out.
// Otherwise the block emits '-' for a negative number, then the digits from most to
// least significant, one word per valid strobe, last high on the final word.
// The receiver cannot stall: each word is on the outputs for exactly one cycle.
// Digits come from one shared 32x32 multiplier: the magnitude times the reciprocal
// of the radix, then the quotient times the radix, then a compare-and-subtract
// correction, in states ST_MUL_RECIP, ST_MUL_BACK and ST_FIX for each digit. Words
// are then emitted one per cycle. busy drops as the last word is launched, so the
// next start may follow.
// Reset clears the registers (leaving an invalid alphabet) and the sequencer.
module signed_radix_to_symbols_unit import sr2s_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               start,
  input  logic signed [31:0] number,
  output logic               busy,
  output logic               valid,
  output logic [7:0]         symbol,
  output logic               last
);

  // Configuration registers
  logic [4:0]  base_length;
  logic [63:0] digit_symbols_low;
  logic [63:0] digit_symbols_high;

  // Sequencer and datapath registers
  state_t      state, state_next;
  logic [31:0] mag;
  logic        neg;
  logic [4:0]  radix;
  logic [31:0] recip;
  logic [63:0] prod;
  logic [31:0] quot;
  logic [5:0]  count;
  logic [3:0]  digits [32];

  logic        alpha_ok;
  logic        accept;
  logic        wr_en;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] diff;
  logic        over;
  logic [3:0]  digit_val;
  logic [31:0] q_fix;
  logic [5:0]  cnt_m1;
  logic        valid_next;
  logic [7:0]  symbol_next;
  logic        last_next;

  // APB register file
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_length        <= '0;
      digit_symbols_low  <= '0;
      digit_symbols_high <= '0;
    end else if (wr_en) begin
      case (paddr[4:3])
        REG_BASE_LENGTH:  base_length        <= pwdata[4:0];
        REG_SYMBOLS_LOW:  digit_symbols_low  <= pwdata;
        REG_SYMBOLS_HIGH: digit_symbols_high <= pwdata;
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_BASE_LENGTH:  prdata = {59'd0, base_length};
      REG_SYMBOLS_LOW:  prdata = digit_symbols_low;
      REG_SYMBOLS_HIGH: prdata = digit_symbols_high;
      default:          prdata = '0;
    endcase
  end

  sr2s_alpha_chk u_alpha_chk (
    .base_length        (base_length),
    .digit_symbols_low  (digit_symbols_low),
    .digit_symbols_high (digit_symbols_high),
    .ok                 (alpha_ok)
  );

  assign busy   = (state != ST_IDLE);
  assign accept = start & ~busy;

  // Shared multiplier: magnitude x reciprocal, then estimated quotient x radix
  always_comb begin
    if (state == ST_MUL_RECIP) begin
      mul_a = mag;
      mul_b = recip;
    end else begin
      mul_a = prod[63:32];
      mul_b = {27'd0, radix};
    end
  end
  assign mul_p = mul_a * mul_b;

  // Correction: remainder is below twice the radix
  assign diff      = mag - prod[31:0];
  assign over      = (diff >= {27'd0, radix});
  assign digit_val = over ? 4'(diff - {27'd0, radix}) : diff[3:0];
  assign q_fix     = over ? quot + 32'd1 : quot;

  assign cnt_m1 = count - 6'd1;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && alpha_ok) state_next = ST_MUL_RECIP;
      end
      ST_MUL_RECIP: state_next = ST_MUL_BACK;
      ST_MUL_BACK:  state_next = ST_FIX;
      ST_FIX: begin
        if (q_fix == 32'd0 || count == 6'd31) begin
          state_next = neg ? ST_SIGN : ST_EMIT;
        end else begin
          state_next = ST_MUL_RECIP;
        end
      end
      ST_SIGN: state_next = ST_EMIT;
      ST_EMIT: begin
        if (count == 6'd1) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output words
  always_comb begin
    valid_next  = 1'b0;
    symbol_next = symbol_at(digit_symbols_low, digit_symbols_high, digits[cnt_m1[4:0]]);
    last_next   = 1'b0;
    case (state)
      ST_SIGN: begin
        valid_next  = 1'b1;
        symbol_next = SYM_MINUS;
      end
      ST_EMIT: begin
        valid_next = 1'b1;
        last_next  = (count == 6'd1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    symbol <= symbol_next;
    last   <= last_next;
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          neg   <= number[31];
          mag   <= number[31] ? 32'd0 - 32'(number) : 32'(number);
          radix <= base_length;
          recip <= recip_of(base_length);
          count <= '0;
        end
      end
      ST_MUL_RECIP: prod <= mul_p;
      ST_MUL_BACK: begin
        quot <= prod[63:32];
        prod <= mul_p;
      end
      ST_FIX: begin
        digits[count[4:0]] <= digit_val;
        count              <= count + 6'd1;
        mag                <= q_fix;
      end
      ST_EMIT: count <= cnt_m1;
      default: ;
    endcase
  end

endmodule

// ----- hdl/sr2s_alpha_chk.sv -----
// Alphabet check: radix range, printable symbols, no signs, no repeats.
module sr2s_alpha_chk import sr2s_pkg::*; (
  input  logic [4:0]  base_length,
  input  logic [63:0] digit_symbols_low,
  input  logic [63:0] digit_symbols_high,
  output logic        ok
);

  logic [7:0] syms [16];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      syms[i] = symbol_at(digit_symbols_low, digit_symbols_high, 4'(i));
    end
  end

  // Only the first base_length symbols count
  always_comb begin
    ok = (base_length >= 5'd2) && (base_length <= MAX_RADIX);
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < base_length) begin
        if (syms[i] <= SYM_SPACE || syms[i] > SYM_TILDE ||
            syms[i] == SYM_PLUS || syms[i] == SYM_MINUS) begin
          ok = 1'b0;
        end
        for (int j = 0; j < i; j++) begin
          if (syms[j] == syms[i]) begin
            ok = 1'b0;
          end
        end
      end
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking bench for the radix-to-symbols unit: directed table, then random alphabets.
`timescale 1ns / 1ps

module tb import sr2s_pkg::*; ();

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 12;
  // longest conversion: the minimum integer in radix 2
  localparam int SETTLE_CYCLES = 150;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 300;
  localparam int MAX_GAP       = 16;
  // no register lives at this index; writes there must be dropped
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } text_word_t;

  typedef enum {ROW_ALPHABET, ROW_REGISTER, ROW_NUMBER} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [1:0]         idx;
    logic [63:0]        data;
    logic signed [31:0] num;
    bit                 typed;
    string              text;
  } stim_row_t;

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [4:0]         paddr   = '0;
  logic [63:0]        pwdata  = '0;
  logic [63:0]        prdata;
  logic               pready;
  logic               start   = 1'b0;
  logic signed [31:0] number  = '0;
  logic               busy;
  logic               valid;
  logic [7:0]         symbol;
  logic               last;

  // words still owed by the block, oldest first
  text_word_t pending_words[$];
  stim_row_t  directed_rows[$];

  // shadow of the register file
  logic [4:0]  cfg_base_length  = '0;
  logic [63:0] cfg_symbols_low  = '0;
  logic [63:0] cfg_symbols_high = '0;

  int errors       = 0;
  int stall_cycles = 0;
  bit numbers_since_config = 1'b0;

  signed_radix_to_symbols_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .start   (start),
    .number  (number),
    .busy    (busy),
    .valid   (valid),
    .symbol  (symbol),
    .last    (last)
  );

  always #HALF_PERIOD clk = ~clk;

  // symbol for one digit value from the shadow alphabet
  function automatic logic [7:0] digit_glyph(input logic [3:0] v);
    logic [63:0] w;
    w = v[3] ? cfg_symbols_high : cfg_symbols_low;
    return w[v[2:0] * 8 +: 8];
  endfunction

  // length in range, printable, no sign characters, no repeats
  function automatic bit alphabet_ok();
    logic [7:0] s;
    if (cfg_base_length < 5'd2 || cfg_base_length > MAX_RADIX) return 1'b0;
    for (int i = 0; i < cfg_base_length; i++) begin
      s = digit_glyph(i[3:0]);
      if (s <= SYM_SPACE || s > SYM_TILDE || s == SYM_PLUS || s == SYM_MINUS) return 1'b0;
      for (int j = 0; j < i; j++) begin
        if (digit_glyph(j[3:0]) == s) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // queue the text form of one number under the current alphabet
  function automatic void predict_text(input logic signed [31:0] value);
    logic [31:0] mag;
    logic [31:0] radix;
    logic [3:0]  digits[32];
    int          nd;
    if (!alphabet_ok()) return;
    radix = {27'd0, cfg_base_length};
    mag   = value[31] ? 32'd0 - value : value;
    nd    = 0;
    do begin
      digits[nd] = 4'(mag % radix);
      nd++;
      mag = mag / radix;
    end while (mag != 0);
    if (value[31]) pending_words.push_back('{symbol: SYM_MINUS, last: 1'b0});
    for (int k = nd - 1; k >= 0; k--) begin
      pending_words.push_back('{symbol: digit_glyph(digits[k]), last: (k == 0)});
    end
  endfunction

  // random operand: small, shifted, extremes, radix powers, or full range
  function automatic logic signed [31:0] draw_number(input int radix);
    logic [31:0] n;
    logic [31:0] p;
    case ($urandom_range(0, 6))
      0: n = $urandom_range(0, 40);
      1: n = $urandom() >> $urandom_range(1, 31);
      2: begin
        case ($urandom_range(0, 3))
          0: n = 32'h8000_0000;
          1: n = 32'h7FFF_FFFF;
          2: n = 32'h0000_0000;
          default: n = 32'hFFFF_FFFF;
        endcase
      end
      3: begin
        p = 32'd1;
        repeat ($urandom_range(1, 31)) begin
          if (p <= 32'h7FFF_FFFF / radix) p = p * radix;
        end
        n = p - $urandom_range(0, 1);
      end
      default: n = $urandom();
    endcase
    if ($urandom_range(0, 1) == 1) n = 32'd0 - n;
    return n;
  endfunction

  // let the block finish everything in flight
  task automatic drain();
    start <= 1'b0;
    while (pending_words.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    numbers_since_config = 1'b0;
  endtask

  // two-phase register write; only while the block is quiet
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    if (numbers_since_config) drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_BASE_LENGTH:  cfg_base_length  = val[4:0];
      REG_SYMBOLS_LOW:  cfg_symbols_low  = val;
      REG_SYMBOLS_HIGH: cfg_symbols_high = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_alphabet(input logic [4:0] len, input logic [63:0] lo,
                                input logic [63:0] hi);
    write_reg(REG_BASE_LENGTH, {59'd0, len});
    write_reg(REG_SYMBOLS_LOW, lo);
    write_reg(REG_SYMBOLS_HIGH, hi);
  endtask

  // hand one number over; start stays high when the next one follows at once
  task automatic issue_number(input logic signed [31:0] value, input int gap, input bit typed,
                              input string text);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    number <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (typed) begin
      for (int i = 0; i < text.len(); i++) begin
        pending_words.push_back('{symbol: text[i], last: (i == text.len() - 1)});
      end
    end else begin
      predict_text(value);
    end
    numbers_since_config = 1'b1;
  endtask

  task automatic alpha_row(input string text);
    stim_row_t r;
    r.kind = ROW_ALPHABET;
    r.text = text;
    directed_rows.push_back(r);
  endtask

  task automatic reg_row(input logic [1:0] idx, input logic [63:0] data);
    stim_row_t r;
    r.kind = ROW_REGISTER;
    r.idx  = idx;
    r.data = data;
    directed_rows.push_back(r);
  endtask

  task automatic num_row(input logic signed [31:0] value, input bit typed, input string text);
    stim_row_t r;
    r.kind  = ROW_NUMBER;
    r.num   = value;
    r.typed = typed;
    r.text  = text;
    directed_rows.push_back(r);
  endtask

  // compare each strobed word against the oldest expectation
  always @(posedge clk) begin
    text_word_t want;
    if (!rst && valid) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word symbol %h last %b", $time, symbol, last);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (symbol !== want.symbol) begin
          $display("%0t: symbol expected %h got %h", $time, want.symbol, symbol);
          errors++;
        end
        if (last !== want.last) begin
          $display("%0t: last expected %b got %b", $time, want.last, last);
          errors++;
        end
      end
    end
  end

  // watchdog: any accepted number, word or register write counts as progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || valid || (psel && penable && pwrite && pready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t   r;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [7:0]  syms[16];
    logic [7:0]  pool[$];
    logic [7:0]  tmp;
    logic [4:0]  len_reg;
    int          radix;
    int          j;
    int          count;
    int          valid_items;
    bit          burst;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    num_row(32'sd123, 1'b1, "");                  // alphabet invalid out of reset
    num_row(32'h8000_0000, 1'b1, "");
    alpha_row("0123456789");
    num_row(32'sd0, 1'b1, "0");
    num_row(32'h7FFF_FFFF, 1'b1, "2147483647");
    num_row(32'h8000_0000, 1'b1, "-2147483648");
    num_row(-32'sd1, 1'b1, "-1");
    num_row(32'sd1000, 1'b0, "");
    reg_row(REG_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF);  // must leave the alphabet alone
    num_row(32'sd42, 1'b1, "42");
    alpha_row("01");
    num_row(32'h8000_0000, 1'b0, "");             // longest output
    num_row(32'sd1, 1'b1, "1");
    num_row(-32'sd1, 1'b1, "-1");
    num_row(32'h5555_5555, 1'b0, "");
    reg_row(REG_BASE_LENGTH, 64'd3);              // third symbol is a zero byte
    num_row(32'sd9, 1'b1, "");
    alpha_row("0123456789ABCDEF");
    num_row(32'h7FFF_FFFF, 1'b1, "7FFFFFFF");
    num_row(32'h8000_0000, 1'b1, "-80000000");
    num_row(32'hDEAD_BEEF, 1'b0, "");
    num_row(32'sd15, 1'b1, "F");
    reg_row(REG_BASE_LENGTH, 64'd17);             // one past the largest radix
    num_row(32'sd15, 1'b1, "");
    alpha_row("!~");                              // edges of the printable range
    num_row(32'sd5, 1'b1, "~!~");
    alpha_row("0 12");
    num_row(32'sd7, 1'b1, "");
    alpha_row("0+2");
    num_row(32'sd7, 1'b1, "");
    alpha_row("0-2");
    num_row(-32'sd7, 1'b1, "");
    alpha_row("0120");
    num_row(32'sd7, 1'b1, "");
    alpha_row("0");
    num_row(32'sd1, 1'b1, "");
    alpha_row("01");
    reg_row(REG_SYMBOLS_LOW, 64'h0000_0000_0000_7F30);  // DEL is not printable
    num_row(32'sd1, 1'b1, "");
    reg_row(REG_BASE_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
    reg_row(REG_SYMBOLS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    reg_row(REG_SYMBOLS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    num_row(32'sd3, 1'b1, "");

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      case (r.kind)
        ROW_ALPHABET: begin
          lo = '0;
          hi = '0;
          for (int k = 0; k < r.text.len(); k++) begin
            if (k < 8) lo[k * 8 +: 8] = r.text[k];
            else hi[(k - 8) * 8 +: 8] = r.text[k];
          end
          apply_alphabet(5'(r.text.len()), lo, hi);
        end
        ROW_REGISTER: write_reg(r.idx, r.data);
        default: issue_number(r.num, $urandom_range(0, MAX_GAP), r.typed, r.text);
      endcase
    end

    // random alphabets, mostly well formed, each followed by a run of numbers
    for (int c = SYM_SPACE + 1; c <= SYM_TILDE; c++) begin
      if (c != SYM_PLUS && c != SYM_MINUS) pool.push_back(8'(c));
    end
    valid_items = 0;
    while (valid_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: radix = 2;
        1: radix = MAX_RADIX;
        default: radix = $urandom_range(2, MAX_RADIX);
      endcase
      for (int k = 0; k < radix; k++) begin
        j = $urandom_range(k, pool.size() - 1);
        tmp = pool[k];
        pool[k] = pool[j];
        pool[j] = tmp;
        syms[k] = pool[k];
      end
      // bytes past the radix are don't-care
      for (int k = radix; k < 16; k++) syms[k] = 8'($urandom());
      len_reg = 5'(radix);
      if ($urandom_range(0, 5) == 0) begin
        j = $urandom_range(0, radix - 1);
        case ($urandom_range(0, 4))
          0: syms[j] = syms[(j + 1) % radix];
          1: syms[j] = 8'($urandom_range(0, SYM_SPACE));
          2: syms[j] = 8'($urandom_range(SYM_TILDE + 1, 255));
          3: syms[j] = ($urandom_range(0, 1) == 1) ? SYM_PLUS : SYM_MINUS;
          default: begin
            if ($urandom_range(0, 1) == 1) len_reg = 5'($urandom_range(0, 1));
            else len_reg = 5'($urandom_range(MAX_RADIX + 1, 31));
          end
        endcase
      end
      for (int k = 0; k < 16; k++) begin
        if (k < 8) lo[k * 8 +: 8] = syms[k];
        else hi[(k - 8) * 8 +: 8] = syms[k];
      end
      apply_alphabet(len_reg, lo, hi);
      burst = ($urandom_range(0, 2) == 0);
      count = alphabet_ok() ? $urandom_range(20, 40) : 6;
      repeat (count) begin
        issue_number(draw_number(radix), burst ? 0 : $urandom_range(0, MAX_GAP), 1'b0, "");
        if (alphabet_ok()) valid_items++;
      end
    end

    drain();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
